// ===== rtl/bsim_pkg.sv =====
// Shared constants, types and command codes of the bucketed sparse identifier map.
package bsim_pkg;

  localparam int unsigned BUCKET_COUNT     = 16;
  localparam int unsigned SLOTS_PER_BUCKET = 32;
  localparam int unsigned VALUE_BITS       = 32;

  localparam int unsigned SLOT_TOTAL  = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int unsigned BucketIdxW  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned OffW        = $clog2(SLOTS_PER_BUCKET);
  localparam int unsigned SlotAddrW   = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int unsigned FillW       = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned IdentW      = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  load;
    logic                  scan_en;
    logic [BucketIdxW-1:0] scan_idx;
    logic                  rd_en;
    logic                  commit;
    logic                  clr_en;
    logic [SlotAddrW-1:0]  clr_addr;
  } dp_cmd_t;

endpackage

// ===== rtl/bsim_ctrl.sv =====
// Controller state machine: clearing pass, bucket scan, slot read and commit sequencing.
module bsim_ctrl import bsim_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_READ   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  localparam logic [BucketIdxW-1:0] ScanLast  = BucketIdxW'(BUCKET_COUNT - 1);
  localparam logic [SlotAddrW-1:0]  ClearLast = SlotAddrW'(SLOT_TOTAL - 1);

  state_e                state_q, state_d;
  logic [BucketIdxW-1:0] scan_cnt_q, scan_cnt_d;
  logic [SlotAddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;
  logic                  out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    scan_cnt_d  = scan_cnt_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.scan_idx = scan_cnt_q;
    cmd_o.clr_addr = clr_cnt_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ClearLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          scan_cnt_d = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        scan_cnt_d    = scan_cnt_q + 1'b1;
        if (scan_cnt_q == ScanLast) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the word
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_cnt_q  <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN && scan_cnt_q == '0))
    else $error("accepted word did not start a scan at bucket zero");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (out_valid_q && state_q == ST_IDLE))
    else $error("commit did not present a result");

endmodule

// ===== rtl/bsim_datapath.sv =====
// Datapath: request registers, bucket table, slot memory, scan tracking and result registers.
module bsim_datapath import bsim_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  input  logic [1:0]            command_i,
  input  logic [IdentW-1:0]     ident_i,
  input  logic [31:0]           value_in_i,
  output logic [31:0]           value_out_o,
  output logic [1:0]            status_o
);

  // request
  logic [1:0]            command_q;
  logic [IdentW-1:0]     ident_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [IdentW-1:0]     base;
  logic [OffW-1:0]       offset;

  // bucket table
  logic                  bucket_valid_q [BUCKET_COUNT];
  logic [IdentW-1:0]     bucket_base_q  [BUCKET_COUNT];
  logic [FillW-1:0]      bucket_fill_q  [BUCKET_COUNT];

  // scan results
  logic                  match_found_q, free_found_q;
  logic [BucketIdxW-1:0] match_idx_q, free_idx_q;
  logic [FillW-1:0]      match_fill_q;
  logic                  scan_hit, scan_free;

  // slot memory
  logic [VALUE_BITS-1:0] slot_mem [SLOT_TOTAL];
  logic [VALUE_BITS-1:0] slot_rd_q;
  logic [SlotAddrW-1:0]  rd_addr, wr_addr;
  logic                  mem_we;
  logic [VALUE_BITS-1:0] mem_wdata;

  // commit decisions
  logic                  slot_we;
  logic [BucketIdxW-1:0] slot_idx;
  logic [VALUE_BITS-1:0] slot_wdata;
  logic                  tbl_we;
  logic [BucketIdxW-1:0] tbl_idx;
  logic                  tbl_valid_d;
  logic [IdentW-1:0]     tbl_base_d;
  logic [FillW-1:0]      tbl_fill_d;
  logic [31:0]           value_out_d;
  status_e               status_d;
  logic [31:0]           value_out_q;
  status_e               status_q;
  logic                  val_nz, slot_nz, do_store, do_remove;
  logic [FillW-1:0]      fill_dec;

  assign offset = OffW'(ident_q % SLOTS_PER_BUCKET);
  assign base   = ident_q - (ident_q % SLOTS_PER_BUCKET);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q <= command_i;
      ident_q   <= ident_i;
      value_q   <= VALUE_BITS'(value_in_i);
    end
  end

  assign scan_hit  = bucket_valid_q[cmd_i.scan_idx] &&
                     (bucket_base_q[cmd_i.scan_idx] == base);
  assign scan_free = !bucket_valid_q[cmd_i.scan_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else if (cmd_i.load) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else if (cmd_i.scan_en) begin
      // keep the lowest-numbered match and the lowest-numbered free bucket
      if (scan_hit && !match_found_q) begin
        match_found_q <= 1'b1;
      end
      if (scan_free && !free_found_q) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (scan_hit && !match_found_q) begin
        match_idx_q  <= cmd_i.scan_idx;
        match_fill_q <= bucket_fill_q[cmd_i.scan_idx];
      end
      if (scan_free && !free_found_q) begin
        free_idx_q <= cmd_i.scan_idx;
      end
    end
  end

  // commit decision from the scan and the slot read
  assign val_nz    = |value_q;
  assign slot_nz   = match_found_q && (|slot_rd_q);
  assign do_store  = (command_q == CMD_INSERT) && val_nz;
  assign do_remove = (command_q == CMD_REMOVE) || ((command_q == CMD_INSERT) && !val_nz);
  assign fill_dec  = (match_fill_q == '0) ? '0 : match_fill_q - 1'b1;

  always_comb begin
    slot_we     = 1'b0;
    slot_idx    = match_idx_q;
    slot_wdata  = value_q;
    tbl_we      = 1'b0;
    tbl_idx     = match_idx_q;
    tbl_valid_d = 1'b1;
    tbl_base_d  = base;
    tbl_fill_d  = match_fill_q;
    value_out_d = '0;
    status_d    = STATUS_DONE;

    if (do_store) begin
      if (match_found_q) begin
        slot_we    = 1'b1;
        tbl_we     = 1'b1;
        tbl_fill_d = slot_nz ? match_fill_q : match_fill_q + 1'b1;
      end else if (free_found_q) begin
        // claim a free bucket: its slots are all empty
        slot_we    = 1'b1;
        slot_idx   = free_idx_q;
        tbl_we     = 1'b1;
        tbl_idx    = free_idx_q;
        tbl_fill_d = FillW'(1);
      end else begin
        status_d = STATUS_FULL;
      end
    end else if (do_remove) begin
      if (slot_nz) begin
        slot_we    = 1'b1;
        slot_wdata = '0;
        tbl_we     = 1'b1;
        tbl_fill_d = fill_dec;
        if (fill_dec == '0) begin
          tbl_valid_d = 1'b0;
          tbl_base_d  = '0;
        end
      end else begin
        status_d = STATUS_ABSENT;
      end
    end else if (command_q == CMD_SEARCH) begin
      if (slot_nz) begin
        value_out_d = 32'(slot_rd_q);
      end else begin
        status_d = STATUS_ABSENT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        bucket_valid_q[i] <= 1'b0;
        bucket_base_q[i]  <= '0;
        bucket_fill_q[i]  <= '0;
      end
    end else if (cmd_i.commit && tbl_we) begin
      bucket_valid_q[tbl_idx] <= tbl_valid_d;
      bucket_base_q[tbl_idx]  <= tbl_base_d;
      bucket_fill_q[tbl_idx]  <= tbl_fill_d;
    end
  end

  assign rd_addr   = SlotAddrW'(match_idx_q) * SlotAddrW'(SLOTS_PER_BUCKET)
                     + SlotAddrW'(offset);
  assign wr_addr   = cmd_i.clr_en ? cmd_i.clr_addr
                     : SlotAddrW'(slot_idx) * SlotAddrW'(SLOTS_PER_BUCKET)
                       + SlotAddrW'(offset);
  assign mem_we    = cmd_i.clr_en || (cmd_i.commit && slot_we);
  assign mem_wdata = cmd_i.clr_en ? '0 : slot_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      slot_rd_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      value_out_q <= value_out_d;
      status_q    <= status_d;
    end
  end

  assign value_out_o = value_out_q;
  assign status_o    = status_q;

  a_free_bucket_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_en && !bucket_valid_q[cmd_i.scan_idx]) |-> (bucket_fill_q[cmd_i.scan_idx] == '0))
    else $error("free bucket with a nonzero fill count");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_en |-> (bucket_fill_q[cmd_i.scan_idx] <= FillW'(SLOTS_PER_BUCKET)))
    else $error("bucket fill count beyond the slot count");

  a_match_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en && match_found_q) |->
      (bucket_valid_q[match_idx_q] && bucket_base_q[match_idx_q] == base))
    else $error("matched bucket does not hold the identifier");

endmodule

// ===== rtl/bucketed_sparse_id_map_unit.sv =====
// Top level of the bucketed sparse identifier map: controller and datapath.
//
//   channel | signals                                   | dir | accepted when
//   --------+-------------------------------------------+-----+----------------------------
//   in      | in_valid_i, in_ready_o, command_i,        | in  | in_valid_i && in_ready_o
//           | ident_i, value_in_i                       |     |
//   out     | out_valid_o, out_ready_i, value_out_o,    | out | out_valid_o && out_ready_i
//           | status_o                                  |     |
//
// One word at a time: accept, a scan of the bucket entries (16) at one entry per cycle,
// one slot memory read, one commit; the bucket scan takes the largest share of each word.
// After reset the slot memory is cleared one entry a cycle, all 512 with in_ready_o low.
// The result sits in an output register; a stalled output holds only the commit
// of the next word, not its acceptance and scan.
module bucketed_sparse_id_map_unit import bsim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] ident_i,
  input  logic [31:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_out_o,
  output logic [1:0]  status_o
);

  dp_cmd_t dp_cmd;

  bsim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  bsim_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .command_i   (command_i),
    .ident_i     (ident_i),
    .value_in_i  (value_in_i),
    .value_out_o (value_out_o),
    .status_o    (status_o)
  );

endmodule
